// ===== src/spe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the shortest path engine.
// ----------------------------------------------------------------------------
package spe_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam int DIST_BITS = 24;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] b;
		logic [15:0] w;
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD1,
		S_ADD2,
		S_CLR,
		S_QINIT,
		S_QSEED,
		S_POP0,
		S_POP1,
		S_POP2,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_NODE_RD,
		S_NODE_CHK,
		S_EDGE_RD,
		S_EDGE_DST,
		S_EDGE_CHK,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_RESULT_RD,
		S_RESULT,
		S_OUT
	} bstate_t;

endpackage : spe_pkg
`default_nettype wire

// ===== src/spe_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spe_in_if / spe_out_if
// Valid/ready channels that carry commands in and query results out.
// ----------------------------------------------------------------------------
interface spe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  node_a;
	logic [7:0]  node_b;
	logic [15:0] weight;
	modport source (output valid, opcode, node_a, node_b, weight, input ready);
	modport sink (input valid, opcode, node_a, node_b, weight, output ready);
endinterface

interface spe_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] distance;
	logic        reachable;
	logic [7:0]  predecessor;
	logic        store_overflow;
	modport source (output valid, distance, reachable, predecessor, store_overflow,
		input ready);
	modport sink (input valid, distance, reachable, predecessor, store_overflow,
		output ready);
endinterface
`default_nettype wire

// ===== src/spe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spe_front
// Accepts commands, drops unused opcodes and queues the rest in a short FIFO.
// ----------------------------------------------------------------------------
module spe_front
	import spe_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	spe_in_if.sink in_ch,
	output cmd_t  cmd,
	output logic  cmd_valid,
	input  wire   cmd_take
);
	cmd_t       fifo_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready && (op_t'(in_ch.opcode) != OP_NONE);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{op: op_t'(in_ch.opcode), a: in_ch.node_a,
				b: in_ch.node_b, w: in_ch.weight};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end

`ifndef SYNTHESIS
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take from empty queue");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ch.ready) else $error("ready while full");
`endif
endmodule
`default_nettype wire

// ===== src/spe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spe_back
// Executes commands: edge append, graph clear and Dijkstra search with a
// binary heap held in a memory array.
// ----------------------------------------------------------------------------
module spe_back
	import spe_pkg::*;
#(
	parameter int NODES = 256,
	parameter int ENTRY_SLOTS = 2048,
	parameter int WEIGHT_BITS = 16
) (
	input  wire    clk,
	input  wire    arst_n,
	input  cmd_t   cmd,
	input  wire    cmd_valid,
	output logic   cmd_take,
	spe_out_if.source out_ch
);
	localparam int NB = $clog2(NODES);
	localparam int EB = $clog2(ENTRY_SLOTS);
	localparam int HS = ENTRY_SLOTS + 1;
	localparam int HB = $clog2(HS + 1);
	localparam int KB = DIST_BITS + NB;
	localparam int CB = $clog2(ENTRY_SLOTS + 1);

	typedef struct packed {
		logic [NB-1:0]          to;
		logic [WEIGHT_BITS-1:0] w;
		logic                   has_next;
		logic [EB-1:0]          nxt;
	} ent_t;

	// Adjacency store, heap and per-node tables.
	ent_t                 ent_mem [ENTRY_SLOTS];
	logic [KB-1:0]        heap_mem [HS];
	logic [DIST_BITS-1:0] dist_mem [NODES];
	logic [NB-1:0]        pred_mem [NODES];
	logic [EB-1:0]        head_mem [NODES];
	logic [EB-1:0]        tail_mem [NODES];
	logic [NODES-1:0]     used_q, reached_q;

	bstate_t state_q, state_d;
	cmd_t    c_q;
	logic [CB-1:0] cnt_q;
	logic    ovf_q;
	logic [HB-1:0] hsize_q, hi_q, hj_q;
	logic [KB-1:0] key_q, kr_q, kl_q;
	logic [NB-1:0] u_q, v_q, clr_q;
	logic [DIST_BITS-1:0] base_q, cand_q, dv_q;
	logic [EB-1:0] e_q;
	ent_t    er_q;
	logic [EB-1:0] tail_rd_q;
	logic [DIST_BITS-1:0] res_d_q;
	logic [NB-1:0] res_p_q;
	logic    res_r_q, add_first_q, have_l_q, have_r_q;
	logic [KB-1:0] hr_q;

	logic a_ok, b_ok;
	logic [NB-1:0] an, bn;
	logic [DIST_BITS:0] sum;
	logic [HB:0] lidx, ridx;
	logic store_full, relax, heap_room;
	logic [NODES-1:0] seed_mask;
	logic sift_swap;
	logic [HB-1:0] sift_m;
	logic [KB-1:0] sift_mk;

	assign a_ok = ({24'd0, c_q.a} < 32'(NODES));
	assign b_ok = ({24'd0, c_q.b} < 32'(NODES));
	assign an = NB'(c_q.a);
	assign bn = NB'(c_q.b);
	assign sum = {1'b0, base_q} + (DIST_BITS+1)'(er_q.w);
	assign lidx = {hi_q, 1'b1};
	assign ridx = lidx + (HB+1)'(1);
	assign store_full = (cnt_q > CB'(ENTRY_SLOTS - 2));
	assign relax = !reached_q[v_q] || (cand_q < dv_q);
	assign heap_room = (hsize_q < HB'(HS));
	assign seed_mask = {{(NODES-1){1'b0}}, 1'b1} << an;

	// Sift-down: pick the smallest of the moving key and its children.
	always_comb begin
		sift_m = hi_q;
		sift_mk = key_q;
		if (have_l_q && kl_q < sift_mk) begin
			sift_m = lidx[HB-1:0];
			sift_mk = kl_q;
		end
		if (have_r_q && kr_q < sift_mk) begin
			sift_m = ridx[HB-1:0];
			sift_mk = kr_q;
		end
		sift_swap = (sift_m != hi_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (cmd_valid) begin
				case (cmd.op)
					OP_ADD: state_d = S_ADD1;
					OP_CLEAR: state_d = S_CLR;
					OP_QUERY: state_d = S_QINIT;
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD1: state_d = (!a_ok || !b_ok || store_full) ? S_IDLE : S_ADD2;
			S_ADD2: state_d = add_first_q ? S_ADD2 : S_IDLE;
			S_CLR: state_d = S_IDLE;
			S_QINIT: state_d = !(a_ok && b_ok) ? S_OUT
				: (clr_q == NB'(NODES - 1)) ? S_QSEED : S_QINIT;
			S_QSEED: state_d = S_POP0;
			S_POP0: state_d = (hsize_q == '0) ? S_RESULT_RD : S_POP1;
			S_POP1: state_d = S_POP2;
			S_POP2: state_d = S_SIFT_RD;
			S_SIFT_RD: state_d = S_SIFT_CMP;
			S_SIFT_CMP: state_d = sift_swap ? S_SIFT_RD : S_NODE_RD;
			S_NODE_RD: state_d = S_NODE_CHK;
			S_NODE_CHK: state_d = used_q[u_q] ? S_EDGE_RD : S_POP0;
			S_EDGE_RD: state_d = S_EDGE_DST;
			S_EDGE_DST: state_d = S_EDGE_CHK;
			S_EDGE_CHK: begin
				if (relax && heap_room) begin
					state_d = S_PUSH_RD;
				end else begin
					state_d = er_q.has_next ? S_EDGE_RD : S_POP0;
				end
			end
			S_PUSH_RD: begin
				if (hi_q == '0) begin
					state_d = er_q.has_next ? S_EDGE_RD : S_POP0;
				end else begin
					state_d = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				if (!(kl_q > kr_q) || hj_q == '0) begin
					state_d = er_q.has_next ? S_EDGE_RD : S_POP0;
				end else begin
					state_d = S_PUSH_RD;
				end
			end
			S_RESULT_RD: state_d = S_RESULT;
			S_RESULT: state_d = S_OUT;
			S_OUT: state_d = out_ch.ready ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd_take = (state_q == S_IDLE) && cmd_valid;
		out_ch.valid = (state_q == S_OUT);
		out_ch.distance = res_d_q;
		out_ch.reachable = res_r_q;
		out_ch.predecessor = 8'(res_p_q);
		out_ch.store_overflow = ovf_q;
	end

	// Datapath: memories are accessed in clocked blocks only.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (cmd_valid) begin
				c_q <= cmd;
				add_first_q <= 1'b1;
				clr_q <= '0;
			end
			S_ADD1: tail_rd_q <= tail_mem[an];
			S_ADD2: begin
				// One direction per cycle; the second pass swaps endpoints.
				ent_mem[EB'(cnt_q)] <= '{to: bn, w: WEIGHT_BITS'(c_q.w), has_next: 1'b0,
					nxt: '0};
				if (used_q[an]) begin
					ent_mem[tail_rd_q].has_next <= 1'b1;
					ent_mem[tail_rd_q].nxt <= EB'(cnt_q);
				end else begin
					head_mem[an] <= EB'(cnt_q);
				end
				tail_mem[an] <= EB'(cnt_q);
				if (add_first_q) begin
					c_q.a <= c_q.b;
					c_q.b <= c_q.a;
					add_first_q <= 1'b0;
					tail_rd_q <= (an == bn) ? EB'(cnt_q) : tail_mem[bn];
				end
			end
			S_QINIT: begin
				clr_q <= clr_q + NB'(1);
				if (!(a_ok && b_ok)) begin
					res_d_q <= '0;
					res_p_q <= '0;
				end
			end
			S_QSEED: begin
				dist_mem[an] <= '0;
				pred_mem[an] <= an;
				heap_mem[0] <= KB'(an);
			end
			S_POP0: begin
				hr_q <= heap_mem[0];
			end
			S_POP1: begin
				key_q <= heap_mem[hsize_q - HB'(1)];
				u_q <= hr_q[NB-1:0];
				hi_q <= '0;
			end
			S_POP2: heap_mem[0] <= key_q;
			S_SIFT_RD: begin
				if (lidx < {1'b0, hsize_q}) kl_q <= heap_mem[lidx[HB-1:0]];
				if (ridx < {1'b0, hsize_q}) kr_q <= heap_mem[ridx[HB-1:0]];
				have_l_q <= (lidx < {1'b0, hsize_q});
				have_r_q <= (ridx < {1'b0, hsize_q});
			end
			S_SIFT_CMP: begin
				if (sift_swap) begin
					heap_mem[sift_m] <= key_q;
					heap_mem[hi_q] <= sift_mk;
					hi_q <= sift_m;
				end
			end
			S_NODE_RD: begin
				base_q <= dist_mem[u_q];
				e_q <= head_mem[u_q];
			end
			S_EDGE_RD: er_q <= ent_mem[e_q];
			S_EDGE_DST: begin
				dv_q <= dist_mem[er_q.to];
				cand_q <= sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
				v_q <= er_q.to;
			end
			S_EDGE_CHK: begin
				if (relax) begin
					dist_mem[v_q] <= cand_q;
					pred_mem[v_q] <= u_q;
					if (heap_room) heap_mem[hsize_q] <= {cand_q, v_q};
					hi_q <= hsize_q;
				end
				e_q <= er_q.nxt;
			end
			S_PUSH_RD: begin
				hj_q <= (hi_q - HB'(1)) >> 1;
				kl_q <= heap_mem[(hi_q - HB'(1)) >> 1];
				kr_q <= heap_mem[hi_q];
			end
			S_PUSH_CMP: begin
				if (kl_q > kr_q) begin
					heap_mem[hj_q] <= kr_q;
					heap_mem[hi_q] <= kl_q;
				end
				hi_q <= hj_q;
			end
			S_RESULT_RD: begin
				res_d_q <= dist_mem[bn];
				res_p_q <= pred_mem[bn];
			end
			S_RESULT: begin
				if (!reached_q[bn]) begin
					res_d_q <= '0;
					res_p_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			reached_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			hsize_q <= '0;
			res_r_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_ADD1: if (a_ok && b_ok && store_full) ovf_q <= 1'b1;
				S_ADD2: begin
					used_q[an] <= 1'b1;
					cnt_q <= cnt_q + CB'(1);
				end
				S_CLR: begin
					used_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				S_QINIT: begin
					reached_q <= (a_ok && b_ok) ? seed_mask : '0;
					res_r_q <= 1'b0;
					hsize_q <= HB'(1);
				end
				S_POP1: hsize_q <= hsize_q - HB'(1);
				S_EDGE_CHK: begin
					if (relax) begin
						reached_q[v_q] <= 1'b1;
						if (heap_room) hsize_q <= hsize_q + HB'(1);
					end
				end
				S_RESULT: res_r_q <= reached_q[bn];
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == S_IDLE) else $error("command taken while busy");
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CB'(ENTRY_SLOTS)) else $error("entry count overrun");
`endif
endmodule
`default_nettype wire

// ===== src/shortest_path_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_path_engine_unit
// Graph store with Dijkstra shortest-path queries.
// ----------------------------------------------------------------------------
// Usage: commands enter on in_ch (opcode, node_a, node_b, weight). Add
// stores an undirected edge; clear empties the graph; an
// unused opcode is discarded by the front end. A query runs Dijkstra from
// node_a and delivers one transfer on out_ch with distance, reachable,
// predecessor and the sticky overflow flag.
// A query first steps through every node to reset the visited flags,
// then for each popped node sifts the heap down level by level, and for
// each adjacency entry that relaxes a node sifts the pushed key up.
// The front end holds up to two commands, so it keeps accepting while the
// back end works. When out_ch stalls the result holds and the back end
// waits; the queue then fills and in_ch ready falls.
// Reset empties the graph and the queue; memories need no clearing pass.
// ----------------------------------------------------------------------------
module shortest_path_engine_unit
	import spe_pkg::*;
#(
	parameter int NODES = 256,
	parameter int ENTRY_SLOTS = 2048,
	parameter int WEIGHT_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	spe_in_if.sink in_ch,
	spe_out_if.source out_ch
);
	cmd_t cmd;
	logic cmd_valid, cmd_take;

	spe_front u_front (
		.clk, .arst_n, .in_ch, .cmd, .cmd_valid, .cmd_take
	);

	spe_back #(.NODES(NODES), .ENTRY_SLOTS(ENTRY_SLOTS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take, .out_ch
	);
endmodule
`default_nettype wire
